FILE: sv/khne_pkg.sv
// shared types, codes and bit-search helpers for the k-hop neighbor expander
// no dependencies
package khne_pkg;

  localparam int NODE_W    = 6;
  localparam int OP_W      = 2;
  localparam int HOP_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int SCAN_W    = 64;

  localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HOP_DISTANCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUMULATIVE_MODE = 1'd1;

  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              hit;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] nbr;
  } cmd_t;

  typedef struct packed {
    logic [HOP_W-1:0] hop;
    logic             cum;
  } cfg_t;

  function automatic logic [NODE_W-1:0] lowest_set(input logic [SCAN_W-1:0] m);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (m[i]) idx = NODE_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [NODE_W-1:0] highest_set(input logic [SCAN_W-1:0] m);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < SCAN_W; i++) begin
      if (m[i]) idx = NODE_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: sv/khne_ifs.sv
// valid/ready channel interfaces: input items, result items, internal command queue
// depends on khne_pkg
interface khne_in_if;
  import khne_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [NODE_W-1:0] node_index;
  logic [NODE_W-1:0] neighbor_index;
  modport source (output valid, opcode, node_index, neighbor_index, input ready);
  modport sink (input valid, opcode, node_index, neighbor_index, output ready);
endinterface

interface khne_out_if;
  import khne_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] queried_node;
  logic [NODE_W-1:0] found_node;
  logic              found_valid;
  logic              last_of_list;
  modport source (output valid, queried_node, found_node, found_valid, last_of_list,
                  input ready);
  modport sink (input valid, queried_node, found_node, found_valid, last_of_list,
                output ready);
endinterface

interface khne_cmd_if;
  import khne_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/khne_front.sv
// front end: config registers, item accept, opcode decode and range checks
// depends on khne_pkg, khne_ifs
module khne_front #(
  parameter int MAX_NODES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  khne_in_if.sink                           in_ch,
  input  logic                              cfg_we,
  input  logic [khne_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [khne_pkg::HOP_W-1:0]        cfg_data,
  khne_cmd_if.source                        cmd,
  output khne_pkg::cfg_t                    cfg
);
  import khne_pkg::*;

  logic [HOP_W-1:0] hop_r;
  logic             cum_r;
  logic             keep;
  logic             node_ok;
  logic             nbr_ok;
  cmd_kind_t        kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r <= HOP_W'(2);
      cum_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOP_DISTANCE:    hop_r <= cfg_data;
        CFG_CUMULATIVE_MODE: cum_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.hop = hop_r;
  assign cfg.cum = cum_r;

  assign node_ok = int'(in_ch.node_index) < MAX_NODES;
  assign nbr_ok  = int'(in_ch.neighbor_index) < MAX_NODES;

  always_comb begin
    keep = 1'b0;
    kind = CMD_QUERY;
    unique case (in_ch.opcode)
      OP_ADD_EDGE: begin
        kind = CMD_EDGE;
        keep = node_ok && nbr_ok;
      end
      OP_QUERY: begin
        kind = CMD_QUERY;
        keep = 1'b1;
      end
      OP_CLEAR: begin
        kind = CMD_CLEAR;
        keep = 1'b1;
      end
      default: ;
    endcase
  end

  // dropped items are accepted at queue pace to keep ordering simple
  assign cmd.data.kind = kind;
  assign cmd.data.hit  = node_ok;
  assign cmd.data.node = in_ch.node_index;
  assign cmd.data.nbr  = in_ch.neighbor_index;
  assign cmd.valid     = in_ch.valid && keep;
  assign in_ch.ready   = cmd.ready;

endmodule

FILE: sv/khne_fifo.sv
// two-entry command queue between front end and back end
// depends on khne_pkg, khne_ifs
module khne_fifo (
  input  logic       clk,
  input  logic       rst_n,
  khne_cmd_if.sink   s,
  khne_cmd_if.source m
);
  import khne_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cmd_t          ent_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          push;
  logic          pop;

  assign s.ready = cnt_r != CW'(DEPTH);
  assign m.valid = cnt_r != '0;
  assign m.data  = ent_r[rd_ptr_r];
  assign push    = s.valid && s.ready;
  assign pop     = m.valid && m.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= s.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/khne_back.sv
// back end: adjacency row memory, layer-by-layer expansion sequencer, result emitter
// depends on khne_pkg, khne_ifs
module khne_back #(
  parameter int MAX_NODES = 64,
  parameter int MAX_HOPS  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  khne_cmd_if.sink       cmd,
  input  khne_pkg::cfg_t cfg,
  khne_out_if.source     out_ch
);
  import khne_pkg::*;

  localparam int NW = MAX_NODES;
  localparam int AW = $clog2(MAX_NODES);
  localparam int KW = $clog2(MAX_HOPS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EDGE = 5'b00010,
    S_ROOT = 5'b00100,
    S_SCAN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NW-1:0]     mem [NW];
  logic [NW-1:0]     row_vld_r;
  logic [NW-1:0]     rd_data_r;
  logic              rd_hit_r;
  logic              rd_pend_r;
  logic [NODE_W-1:0] qnode_r, qnode_nxt;
  logic [NODE_W-1:0] nbr_r, nbr_nxt;
  logic [NW-1:0]     prev1_r, prev1_nxt;
  logic [NW-1:0]     prev2_r, prev2_nxt;
  logic [NW-1:0]     acc_r, acc_nxt;
  logic [NW-1:0]     pend_r, pend_nxt;
  logic [NW-1:0]     res_r, res_nxt;
  logic [KW-1:0]     layer_r, layer_nxt;
  logic              asc_r, asc_nxt;
  logic              empty_r, empty_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [NODE_W-1:0] out_q_r, out_q_nxt;
  logic [NODE_W-1:0] out_f_r, out_f_nxt;
  logic              out_fv_r, out_fv_nxt;
  logic              out_last_r, out_last_nxt;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [NW-1:0]     wr_data;
  logic              clr;
  logic [NW-1:0]     row_val;
  logic [NW-1:0]     cur;
  logic [NW-1:0]     res_sel;
  logic [NW-1:0]     res_rem;
  logic [NODE_W-1:0] pick_lo;
  logic [NODE_W-1:0] pick_out;
  logic [KW-1:0]     k_c;
  logic              out_free;
  logic              last_layer;

  always_comb begin
    if (cfg.hop == '0) k_c = KW'(1);
    else if (int'(cfg.hop) > MAX_HOPS) k_c = KW'(MAX_HOPS);
    else k_c = KW'(cfg.hop);
  end

  assign row_val    = rd_hit_r ? rd_data_r : '0;
  assign cur        = acc_r & ~prev1_r & ~prev2_r;
  assign last_layer = layer_r == k_c;
  assign res_sel    = (cfg.cum || last_layer) ? (res_r | cur) : res_r;
  assign pick_lo    = lowest_set(SCAN_W'(pend_r));
  assign pick_out   = asc_r ? lowest_set(SCAN_W'(res_r)) : highest_set(SCAN_W'(res_r));
  assign res_rem    = res_r & ~(NW'(1) << pick_out);
  assign wr_data    = row_val | (NW'(1) << nbr_r);
  assign out_free   = !out_vld_r || out_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    qnode_nxt    = qnode_r;
    nbr_nxt      = nbr_r;
    prev1_nxt    = prev1_r;
    prev2_nxt    = prev2_r;
    acc_nxt      = acc_r;
    pend_nxt     = pend_r;
    res_nxt      = res_r;
    layer_nxt    = layer_r;
    asc_nxt      = asc_r;
    empty_nxt    = empty_r;
    out_vld_nxt  = out_ch.ready ? 1'b0 : out_vld_r;
    out_q_nxt    = out_q_r;
    out_f_nxt    = out_f_r;
    out_fv_nxt   = out_fv_r;
    out_last_nxt = out_last_r;
    rd_en        = 1'b0;
    rd_addr      = qnode_r[AW-1:0];
    wr_en        = 1'b0;
    clr          = 1'b0;
    cmd.ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          qnode_nxt = cmd.data.node;
          nbr_nxt   = cmd.data.nbr;
          unique case (cmd.data.kind)
            CMD_EDGE: begin
              rd_en     = 1'b1;
              rd_addr   = cmd.data.node[AW-1:0];
              state_nxt = S_EDGE;
            end
            CMD_CLEAR: begin
              clr = 1'b1;
            end
            CMD_QUERY: begin
              if (cmd.data.hit) begin
                rd_en     = 1'b1;
                rd_addr   = cmd.data.node[AW-1:0];
                prev2_nxt = NW'(1) << cmd.data.node;
                state_nxt = S_ROOT;
              end else begin
                res_nxt   = '0;
                asc_nxt   = 1'b0;
                empty_nxt = 1'b1;
                state_nxt = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_EDGE: begin
        wr_en     = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ROOT: begin
        prev1_nxt = row_val;
        if (k_c == KW'(1)) begin
          res_nxt   = row_val;
          asc_nxt   = 1'b1;
          empty_nxt = row_val == '0;
          state_nxt = S_EMIT;
        end else begin
          res_nxt   = cfg.cum ? row_val : '0;
          asc_nxt   = 1'b0;
          layer_nxt = KW'(2);
          pend_nxt  = row_val;
          acc_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_pend_r) acc_nxt = acc_r | row_val;
        if (pend_r != '0) begin
          rd_en    = 1'b1;
          rd_addr  = pick_lo[AW-1:0];
          pend_nxt = pend_r & ~(NW'(1) << pick_lo);
        end else if (!rd_pend_r) begin
          // layer complete
          prev2_nxt = prev1_r;
          prev1_nxt = cur;
          res_nxt   = res_sel;
          if (last_layer) begin
            empty_nxt = res_sel == '0;
            state_nxt = S_EMIT;
          end else begin
            layer_nxt = layer_r + KW'(1);
            pend_nxt  = cur;
            acc_nxt   = '0;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_q_nxt   = qnode_r;
          if (empty_r) begin
            out_f_nxt    = '0;
            out_fv_nxt   = 1'b0;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_f_nxt    = pick_out;
            out_fv_nxt   = 1'b1;
            out_last_nxt = res_rem == '0;
            res_nxt      = res_rem;
            if (res_rem == '0) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // row memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[qnode_r[AW-1:0]] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_hit_r  <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      row_vld_r <= '0;
      rd_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      out_vld_r <= out_vld_nxt;
      if (clr) row_vld_r <= '0;
      else if (wr_en) row_vld_r[qnode_r[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    qnode_r    <= qnode_nxt;
    nbr_r      <= nbr_nxt;
    prev1_r    <= prev1_nxt;
    prev2_r    <= prev2_nxt;
    acc_r      <= acc_nxt;
    pend_r     <= pend_nxt;
    res_r      <= res_nxt;
    layer_r    <= layer_nxt;
    asc_r      <= asc_nxt;
    empty_r    <= empty_nxt;
    out_q_r    <= out_q_nxt;
    out_f_r    <= out_f_nxt;
    out_fv_r   <= out_fv_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.queried_node = out_q_r;
  assign out_ch.found_node   = out_f_r;
  assign out_ch.found_valid  = out_fv_r;
  assign out_ch.last_of_list = out_last_r;

endmodule

FILE: sv/k_hop_neighbor_expander_core.sv
// k-hop neighbor expander top: front end, command queue, expansion back end
// an edge add reads then rewrites the node's row with the neighbor bit set; a clear drops all
// row valid bits; a query reads the root row, then each layer's frontier rows, then emits
// one result per cycle unless stalled; one item at a time in back end, up to two queued
// reset: synchronous active-low; clears all rows (per-row valid bits), k = 2, single-layer mode
module k_hop_neighbor_expander_core #(
  parameter int MAX_NODES = 64,
  parameter int MAX_HOPS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  khne_in_if.sink                        in_ch,
  khne_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [khne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [khne_pkg::HOP_W-1:0]     cfg_data
);
  import khne_pkg::*;

  khne_cmd_if cmd_push ();
  khne_cmd_if cmd_pop ();
  cfg_t       cfg;

  khne_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_push),
    .cfg       (cfg)
  );

  khne_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .s     (cmd_push),
    .m     (cmd_pop)
  );

  khne_back #(
    .MAX_NODES (MAX_NODES),
    .MAX_HOPS  (MAX_HOPS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd_pop),
    .cfg    (cfg),
    .out_ch (out_ch)
  );

endmodule
